// File: hdl/smeu_pkg.sv
`default_nettype none

package smeu_pkg;

	typedef enum logic [3:0] {
		OP_PUSH  = 4'd0,
		OP_POP   = 4'd1,
		OP_ADD   = 4'd2,
		OP_IFEQ  = 4'd3,
		OP_JUMP  = 4'd4,
		OP_PRINT = 4'd5,
		OP_DUP   = 4'd6,
		OP_AND   = 4'd7,
		OP_NAND  = 4'd8,
		OP_OR    = 4'd9,
		OP_NOR   = 4'd10,
		OP_XOR   = 4'd11,
		OP_SHL   = 4'd12,
		OP_ASR   = 4'd13,
		OP_CMP   = 4'd14,
		OP_NOP   = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		FLT_NONE  = 2'd0,
		FLT_UNDER = 2'd1,
		FLT_OVER  = 2'd2
	} fault_t;

	localparam logic [31:0] CMP_EQ = 32'd0;
	localparam logic [31:0] CMP_LT = 32'd1;
	localparam logic [31:0] CMP_GT = 32'd2;
	localparam logic [31:0] CMP_LE = 32'd3;
	localparam logic [31:0] CMP_GE = 32'd4;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 7;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_RD0    = 3'd1,
		ST_RD1    = 3'd2,
		ST_RD2    = 3'd3,
		ST_EXEC   = 3'd4,
		ST_RDTOP  = 3'd5,
		ST_FINISH = 3'd6
	} state_t;

	typedef struct packed {
		logic       load_in;
		logic [1:0] rd_depth;
		logic       cap_a;
		logic       cap_b;
		logic       exec;
		logic       load_out;
	} cmd_t;

endpackage

`default_nettype wire

// File: hdl/smeu_ram.sv
`default_nettype none

module smeu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/smeu_ctrl.sv
`default_nettype none

module smeu_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output logic                done,
	output smeu_pkg::cmd_t      cmd
);

	smeu_pkg::state_t state_q;
	smeu_pkg::state_t state_d;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smeu_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == smeu_pkg::ST_FINISH);
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			smeu_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load_in = 1'b1;
					state_d     = smeu_pkg::ST_RD0;
				end
			end
			smeu_pkg::ST_RD0: begin
				cmd.rd_depth = 2'd0;
				state_d      = smeu_pkg::ST_RD1;
			end
			smeu_pkg::ST_RD1: begin
				cmd.rd_depth = 2'd1;
				cmd.cap_a    = 1'b1;
				state_d      = smeu_pkg::ST_RD2;
			end
			smeu_pkg::ST_RD2: begin
				cmd.rd_depth = 2'd2;
				cmd.cap_b    = 1'b1;
				state_d      = smeu_pkg::ST_EXEC;
			end
			smeu_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = smeu_pkg::ST_RDTOP;
			end
			smeu_pkg::ST_RDTOP: begin
				cmd.rd_depth = 2'd0;
				state_d      = smeu_pkg::ST_FINISH;
			end
			smeu_pkg::ST_FINISH: begin
				cmd.load_out = 1'b1;
				state_d      = smeu_pkg::ST_IDLE;
			end
			default: begin
				state_d = smeu_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != smeu_pkg::ST_IDLE);
	assign done = done_q;

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == smeu_pkg::ST_FINISH))
		else $error("strobe without a finished word");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == smeu_pkg::ST_RD0))
		else $error("accepted word did not start a read");

	a_no_start_while_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smeu_pkg::ST_FINISH) |=> (done_q && !busy))
		else $error("finish did not return to idle with a strobe");

endmodule

`default_nettype wire

// File: hdl/smeu_dp.sv
`default_nettype none

module smeu_dp #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire smeu_pkg::cmd_t                      cmd,
	input  wire logic [3:0]                          op,
	input  wire logic signed [smeu_pkg::WORD_W-1:0]  immediate,
	output logic signed [smeu_pkg::WORD_W-1:0]       top_value,
	output logic [smeu_pkg::COUNT_W-1:0]             stack_count,
	output logic                                     print_valid,
	output logic signed [smeu_pkg::WORD_W-1:0]       print_value,
	output logic                                     jump_taken,
	output logic signed [smeu_pkg::WORD_W-1:0]       jump_target,
	output logic [1:0]                               fault
);

	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int W   = smeu_pkg::WORD_W;
	localparam int CW  = smeu_pkg::COUNT_W;

	smeu_pkg::op_t    op_q;
	logic [W-1:0]     imm_q;
	logic [W-1:0]     a_q;
	logic [W-1:0]     b_q;
	logic [SPW-1:0]   sp_q;

	logic             pv_q;
	logic [W-1:0]     pval_q;
	logic             jt_q;
	logic [W-1:0]     jtar_q;
	smeu_pkg::fault_t fault_q;

	logic [W-1:0]     top_q;
	logic [CW-1:0]    count_q;
	logic             pv_out_q;
	logic [W-1:0]     pval_out_q;
	logic             jt_out_q;
	logic [W-1:0]     jtar_out_q;
	logic [1:0]       fault_out_q;

	logic [W-1:0]     rdata;
	logic [AW-1:0]    raddr;
	logic [SPW-1:0]   rd_ptr;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [W-1:0]     wdata;
	logic [SPW-1:0]   sp_d;
	logic             pv_d;
	logic [W-1:0]     pval_d;
	logic             jt_d;
	logic [W-1:0]     jtar_d;
	smeu_pkg::fault_t fault_d;

	logic [SPW-1:0]   sp_m2;
	logic [SPW-1:0]   sp_m3;
	logic [W-1:0]     alu_r;
	logic             flag;
	logic             flag_known;
	logic [SPW+CW-1:0] sp_ext;

	assign rd_ptr = sp_q - SPW'(cmd.rd_depth) - SPW'(1);
	assign raddr  = rd_ptr[AW-1:0];
	assign sp_m2  = sp_q - SPW'(2);
	assign sp_m3  = sp_q - SPW'(3);

	smeu_ram #(
		.WIDTH(W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		case (op_q)
			smeu_pkg::OP_ADD:  alu_r = a_q + b_q;
			smeu_pkg::OP_AND:  alu_r = a_q & b_q;
			smeu_pkg::OP_NAND: alu_r = ~(a_q & b_q);
			smeu_pkg::OP_OR:   alu_r = a_q | b_q;
			smeu_pkg::OP_NOR:  alu_r = ~(a_q | b_q);
			smeu_pkg::OP_XOR:  alu_r = a_q ^ b_q;
			smeu_pkg::OP_SHL:  alu_r = (b_q > 32'd31) ? '0 : (a_q << b_q[4:0]);
			smeu_pkg::OP_ASR:  alu_r = (b_q > 32'd31) ? '0 : W'($signed(a_q) >>> b_q[4:0]);
			default:           alu_r = '0;
		endcase
	end

	// code on top, then v1, then v2 (v2 arrives straight from the memory)
	always_comb begin
		flag_known = 1'b1;
		case (a_q)
			smeu_pkg::CMP_EQ: flag = (b_q == rdata);
			smeu_pkg::CMP_LT: flag = ($signed(b_q) <  $signed(rdata));
			smeu_pkg::CMP_GT: flag = ($signed(b_q) >  $signed(rdata));
			smeu_pkg::CMP_LE: flag = ($signed(b_q) <= $signed(rdata));
			smeu_pkg::CMP_GE: flag = ($signed(b_q) >= $signed(rdata));
			default: begin
				flag       = 1'b0;
				flag_known = 1'b0;
			end
		endcase
	end

	always_comb begin
		we      = 1'b0;
		waddr   = sp_q[AW-1:0];
		wdata   = imm_q;
		sp_d    = sp_q;
		pv_d    = 1'b0;
		pval_d  = '0;
		jt_d    = 1'b0;
		jtar_d  = '0;
		fault_d = smeu_pkg::FLT_NONE;
		case (op_q)
			smeu_pkg::OP_PUSH: begin
				if (sp_q >= SPW'(STACK_DEPTH)) begin
					fault_d = smeu_pkg::FLT_OVER;
				end else begin
					we   = 1'b1;
					sp_d = sp_q + SPW'(1);
				end
			end
			smeu_pkg::OP_POP: begin
				if (sp_q < SPW'(1)) begin
					fault_d = smeu_pkg::FLT_UNDER;
				end else begin
					sp_d = sp_q - SPW'(1);
				end
			end
			smeu_pkg::OP_IFEQ: begin
				if (sp_q < SPW'(2)) begin
					fault_d = smeu_pkg::FLT_UNDER;
				end else if (a_q == b_q) begin
					if (sp_q < SPW'(3)) begin
						fault_d = smeu_pkg::FLT_UNDER;
					end else begin
						jt_d   = 1'b1;
						jtar_d = rdata;
						sp_d   = sp_m3;
					end
				end else begin
					sp_d = sp_m2;
				end
			end
			smeu_pkg::OP_JUMP: begin
				if (sp_q < SPW'(1)) begin
					fault_d = smeu_pkg::FLT_UNDER;
				end else begin
					jt_d   = 1'b1;
					jtar_d = a_q;
					sp_d   = sp_q - SPW'(1);
				end
			end
			smeu_pkg::OP_PRINT: begin
				if (sp_q < SPW'(1)) begin
					fault_d = smeu_pkg::FLT_UNDER;
				end else begin
					pv_d   = 1'b1;
					pval_d = a_q;
				end
			end
			smeu_pkg::OP_DUP: begin
				if (sp_q < SPW'(1)) begin
					fault_d = smeu_pkg::FLT_UNDER;
				end else if (sp_q >= SPW'(STACK_DEPTH)) begin
					fault_d = smeu_pkg::FLT_OVER;
				end else begin
					we    = 1'b1;
					wdata = a_q;
					sp_d  = sp_q + SPW'(1);
				end
			end
			smeu_pkg::OP_ADD, smeu_pkg::OP_AND, smeu_pkg::OP_NAND, smeu_pkg::OP_OR,
			smeu_pkg::OP_NOR, smeu_pkg::OP_XOR, smeu_pkg::OP_SHL, smeu_pkg::OP_ASR: begin
				if (sp_q < SPW'(2)) begin
					fault_d = smeu_pkg::FLT_UNDER;
				end else begin
					we    = 1'b1;
					waddr = sp_m2[AW-1:0];
					wdata = alu_r;
					sp_d  = sp_q - SPW'(1);
				end
			end
			smeu_pkg::OP_CMP: begin
				if (sp_q < SPW'(3)) begin
					fault_d = smeu_pkg::FLT_UNDER;
				end else if (flag_known) begin
					we    = 1'b1;
					waddr = sp_m3[AW-1:0];
					wdata = {{(W-1){1'b0}}, flag};
					sp_d  = sp_m2;
				end else begin
					sp_d = sp_m3;
				end
			end
			default: begin
			end
		endcase
		if (!cmd.exec) begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.exec) begin
			sp_q <= sp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= smeu_pkg::op_t'(op);
			imm_q <= immediate;
		end
		if (cmd.cap_a) begin
			a_q <= rdata;
		end
		if (cmd.cap_b) begin
			b_q <= rdata;
		end
		if (cmd.exec) begin
			pv_q    <= pv_d;
			pval_q  <= pval_d;
			jt_q    <= jt_d;
			jtar_q  <= jtar_d;
			fault_q <= fault_d;
		end
		if (cmd.load_out) begin
			top_q       <= (sp_q == '0) ? '0 : rdata;
			count_q     <= sp_ext[CW-1:0];
			pv_out_q    <= pv_q;
			pval_out_q  <= pval_q;
			jt_out_q    <= jt_q;
			jtar_out_q  <= jtar_q;
			fault_out_q <= fault_q;
		end
	end

	assign sp_ext      = {{CW{1'b0}}, sp_q};
	assign top_value   = top_q;
	assign stack_count = count_q;
	assign print_valid = pv_out_q;
	assign print_value = pval_out_q;
	assign jump_taken  = jt_out_q;
	assign jump_target = jtar_out_q;
	assign fault       = fault_out_q;

	a_sp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_sp_moves_on_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_q != $past(sp_q)) |-> $past(cmd.exec))
		else $error("stack pointer moved outside execute");

	a_fault_keeps_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && fault_d != smeu_pkg::FLT_NONE) |-> (!we && sp_d == sp_q && !pv_d && !jt_d))
		else $error("faulting word changed the stack or reported");

	a_write_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (sp_q != '0 || op_q == smeu_pkg::OP_PUSH))
		else $error("write to an empty stack by a popping word");

endmodule

`default_nettype wire

// File: hdl/stack_machine_execute_unit.sv
// A word taken while idle passes RD0-RD2 (operand reads), EXEC, RDTOP (new top
// read) and FINISH; done, registered from FINISH, strobes the result. A new
// word is taken only back in idle; busy is high from RD0 through FINISH, set
// by the single read port of the stack memory (three operand reads and a read
// of the new top). The receiver cannot stall; each result shows once.
// Reset (arst_n low, asynchronous): empty stack, controller idle, no strobe.
`default_nettype none

module stack_machine_execute_unit #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [3:0]         op,
	input  wire logic signed [31:0] immediate,
	output logic                    done,
	output logic signed [31:0]      top_value,
	output logic [6:0]              stack_count,
	output logic                    print_valid,
	output logic signed [31:0]      print_value,
	output logic                    jump_taken,
	output logic signed [31:0]      jump_target,
	output logic [1:0]              fault
);

	smeu_pkg::cmd_t cmd;

	smeu_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	smeu_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.op         (op),
		.immediate  (immediate),
		.top_value  (top_value),
		.stack_count(stack_count),
		.print_valid(print_valid),
		.print_value(print_value),
		.jump_taken (jump_taken),
		.jump_target(jump_target),
		.fault      (fault)
	);

endmodule

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb;

	localparam int DEPTH = 64;

	typedef struct packed {
		logic [31:0]      top;
		logic [6:0]       cnt;
		logic             pv;
		logic [31:0]      pval;
		logic             jt;
		logic [31:0]      jtgt;
		smeu_pkg::fault_t flt;
	} word_result_t;

	typedef struct {
		smeu_pkg::op_t op;
		logic [31:0]   imm;
		bit            typed;
		word_result_t  res;
	} dir_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [3:0]         op = smeu_pkg::OP_NOP;
	logic signed [31:0] immediate = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] top_value;
	logic [6:0]         stack_count;
	logic               print_valid;
	logic signed [31:0] print_value;
	logic               jump_taken;
	logic signed [31:0] jump_target;
	logic [1:0]         fault;

	logic [31:0]  shadow_stack [0:DEPTH-1];
	int           shadow_depth = 0;
	int           deepest = 0;
	word_result_t awaited [$];
	word_result_t none_res = '0;
	dir_row_t     dir_rows [$];
	int unsigned  idle_pct = 0;
	int unsigned  idle_plan [3] = '{7, 77, 0};
	int           words_sent = 0;
	int           results_seen = 0;
	int           errors = 0;
	int           n_under = 0;
	int           n_over = 0;
	int           n_jump = 0;
	int           n_print = 0;

	stack_machine_execute_unit #(.STACK_DEPTH(DEPTH)) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.immediate   (immediate),
		.done        (done),
		.top_value   (top_value),
		.stack_count (stack_count),
		.print_valid (print_valid),
		.print_value (print_value),
		.jump_taken  (jump_taken),
		.jump_target (jump_target),
		.fault       (fault)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("** stack_machine_execute_unit: FAILED **");
		$finish;
	end

	task automatic step_stack(input smeu_pkg::op_t o, input logic [31:0] v,
			output word_result_t r);
		int                 n;
		logic [31:0]        a;
		logic [31:0]        b;
		logic [31:0]        res;
		logic [31:0]        code;
		logic signed [31:0] v1;
		logic signed [31:0] v2;
		logic               flag;
		n = shadow_depth;
		r = '0;
		r.flt = smeu_pkg::FLT_NONE;
		case (o)
			smeu_pkg::OP_PUSH: begin
				if (n >= DEPTH) r.flt = smeu_pkg::FLT_OVER;
				else begin
					shadow_stack[n] = v;
					shadow_depth = n + 1;
				end
			end
			smeu_pkg::OP_POP: begin
				if (n < 1) r.flt = smeu_pkg::FLT_UNDER;
				else shadow_depth = n - 1;
			end
			smeu_pkg::OP_IFEQ: begin
				if (n < 2) r.flt = smeu_pkg::FLT_UNDER;
				else if (shadow_stack[n-1] == shadow_stack[n-2]) begin
					if (n < 3) r.flt = smeu_pkg::FLT_UNDER;
					else begin
						r.jt = 1'b1;
						r.jtgt = shadow_stack[n-3];
						shadow_depth = n - 3;
					end
				end else shadow_depth = n - 2;
			end
			smeu_pkg::OP_JUMP: begin
				if (n < 1) r.flt = smeu_pkg::FLT_UNDER;
				else begin
					r.jt = 1'b1;
					r.jtgt = shadow_stack[n-1];
					shadow_depth = n - 1;
				end
			end
			smeu_pkg::OP_PRINT: begin
				if (n < 1) r.flt = smeu_pkg::FLT_UNDER;
				else begin
					r.pv = 1'b1;
					r.pval = shadow_stack[n-1];
				end
			end
			smeu_pkg::OP_DUP: begin
				if (n < 1) r.flt = smeu_pkg::FLT_UNDER;
				else if (n >= DEPTH) r.flt = smeu_pkg::FLT_OVER;
				else begin
					shadow_stack[n] = shadow_stack[n-1];
					shadow_depth = n + 1;
				end
			end
			smeu_pkg::OP_ADD, smeu_pkg::OP_AND, smeu_pkg::OP_NAND, smeu_pkg::OP_OR,
			smeu_pkg::OP_NOR, smeu_pkg::OP_XOR, smeu_pkg::OP_SHL, smeu_pkg::OP_ASR: begin
				if (n < 2) r.flt = smeu_pkg::FLT_UNDER;
				else begin
					a = shadow_stack[n-1];
					b = shadow_stack[n-2];
					case (o)
						smeu_pkg::OP_ADD:  res = a + b;
						smeu_pkg::OP_AND:  res = a & b;
						smeu_pkg::OP_NAND: res = ~(a & b);
						smeu_pkg::OP_OR:   res = a | b;
						smeu_pkg::OP_NOR:  res = ~(a | b);
						smeu_pkg::OP_XOR:  res = a ^ b;
						smeu_pkg::OP_SHL:  res = (b > 32'd31) ? 32'd0 : a << b[4:0];
						default: begin
							res = $signed(a) >>> b[4:0];
							if (b > 32'd31) res = 32'd0;
						end
					endcase
					shadow_stack[n-2] = res;
					shadow_depth = n - 1;
				end
			end
			smeu_pkg::OP_CMP: begin
				if (n < 3) r.flt = smeu_pkg::FLT_UNDER;
				else begin
					code = shadow_stack[n-1];
					v1 = shadow_stack[n-2];
					v2 = shadow_stack[n-3];
					if (code <= smeu_pkg::CMP_GE) begin
						case (code)
							smeu_pkg::CMP_EQ: flag = (v1 == v2);
							smeu_pkg::CMP_LT: flag = (v1 < v2);
							smeu_pkg::CMP_GT: flag = (v1 > v2);
							smeu_pkg::CMP_LE: flag = (v1 <= v2);
							default:          flag = (v1 >= v2);
						endcase
						shadow_stack[n-3] = {31'd0, flag};
						shadow_depth = n - 2;
					end else shadow_depth = n - 3;
				end
			end
			default: ;
		endcase
		r.top = (shadow_depth != 0) ? shadow_stack[shadow_depth-1] : 32'd0;
		r.cnt = shadow_depth[6:0];
		if (shadow_depth > deepest) deepest = shadow_depth;
	endtask

	task automatic issue(input smeu_pkg::op_t o, input logic [31:0] v, input bit typed,
			input word_result_t typed_res);
		word_result_t r;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		immediate <= v;
		do @(posedge clk); while (busy);
		step_stack(o, v, r);
		if (typed) begin
			r.top = typed_res.top;
			r.cnt = typed_res.cnt;
			r.flt = typed_res.flt;
		end
		awaited.push_back(r);
		words_sent++;
	endtask

	task automatic send(input smeu_pkg::op_t o, input logic [31:0] v);
		issue(o, v, 1'b0, none_res);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (awaited.size() != 0);
	endtask

	task automatic add_row(input smeu_pkg::op_t o, input logic [31:0] v, input bit typed,
			input logic [31:0] top, input logic [6:0] cnt, input smeu_pkg::fault_t flt);
		dir_row_t row;
		row.op = o;
		row.imm = v;
		row.typed = typed;
		row.res = '0;
		row.res.top = top;
		row.res.cnt = cnt;
		row.res.flt = flt;
		dir_rows.push_back(row);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h7FFF_FFFF;
			4: return 32'h8000_0000;
			5, 6: return $urandom_range(0, 40);
			default: return $urandom();
		endcase
	endfunction

	task automatic play_sequence();
		int unsigned kind;
		int unsigned n;
		logic [31:0] x;
		logic [31:0] y;
		kind = $urandom_range(0, 19);
		if (shadow_depth > 56 && kind < 10) kind = 16;
		if (kind <= 3) begin
			send(smeu_pkg::OP_PUSH,
				$urandom_range(0, 1) ? $urandom_range(0, 40) : rand_value());
			send(smeu_pkg::OP_PUSH, rand_value());
			n = $urandom_range(0, 7);
			send((n == 0) ? smeu_pkg::OP_ADD :
				smeu_pkg::op_t'(n + 32'(smeu_pkg::OP_DUP)), $urandom());
		end else if (kind <= 6) begin
			x = rand_value();
			y = ($urandom_range(0, 2) == 0) ? x : rand_value();
			send(smeu_pkg::OP_PUSH, x);
			send(smeu_pkg::OP_PUSH, y);
			send(smeu_pkg::OP_PUSH,
				($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 6));
			send(smeu_pkg::OP_CMP, $urandom());
		end else if (kind <= 8) begin
			x = rand_value();
			send(smeu_pkg::OP_PUSH, rand_value());
			send(smeu_pkg::OP_PUSH, x);
			send(smeu_pkg::OP_PUSH, $urandom_range(0, 1) ? x : rand_value());
			send(smeu_pkg::OP_IFEQ, $urandom());
		end else if (kind == 9) begin
			send(smeu_pkg::OP_PUSH, rand_value());
			send(smeu_pkg::OP_JUMP, $urandom());
		end else if (kind == 10) begin
			send($urandom_range(0, 1) ? smeu_pkg::OP_PRINT : smeu_pkg::OP_DUP, $urandom());
		end else if (kind == 14 && $urandom_range(0, 1) == 0) begin
			while (shadow_depth < DEPTH) send(smeu_pkg::OP_PUSH, rand_value());
			repeat ($urandom_range(1, 3))
				send($urandom_range(0, 1) ? smeu_pkg::OP_PUSH : smeu_pkg::OP_DUP,
					$urandom());
		end else if (kind == 15 && $urandom_range(0, 1) == 0) begin
			while (shadow_depth > 0) send(smeu_pkg::OP_POP, $urandom());
			send(smeu_pkg::op_t'($urandom_range(1, 14)), $urandom());
		end else if (kind >= 16) begin
			send(smeu_pkg::OP_POP, $urandom());
		end else begin
			send(smeu_pkg::op_t'($urandom_range(0, 15)), $urandom());
		end
	endtask

	task automatic note_mismatch(input string field, input logic [31:0] exp,
			input logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp, got);
		errors++;
	endtask

	always @(posedge clk) begin : result_check
		word_result_t e;
		if (done) begin
			if (awaited.size() == 0) begin
				$display("%0t: result with no word outstanding", $time);
				errors++;
			end else begin
				e = awaited.pop_front();
				results_seen++;
				if (e.flt == smeu_pkg::FLT_UNDER) n_under++;
				if (e.flt == smeu_pkg::FLT_OVER) n_over++;
				if (e.jt) n_jump++;
				if (e.pv) n_print++;
				if (top_value !== e.top) note_mismatch("top_value", e.top, top_value);
				if (stack_count !== e.cnt)
					note_mismatch("stack_count", 32'(e.cnt), 32'(stack_count));
				if (print_valid !== e.pv)
					note_mismatch("print_valid", 32'(e.pv), 32'(print_valid));
				if (print_value !== e.pval)
					note_mismatch("print_value", e.pval, print_value);
				if (jump_taken !== e.jt)
					note_mismatch("jump_taken", 32'(e.jt), 32'(jump_taken));
				if (jump_target !== e.jtgt)
					note_mismatch("jump_target", e.jtgt, jump_target);
				if (fault !== e.flt) note_mismatch("fault", 32'(e.flt), 32'(fault));
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(smeu_pkg::OP_POP,   $urandom(),    1'b1, 32'd0,   7'd0, smeu_pkg::FLT_UNDER);
		add_row(smeu_pkg::OP_CMP,   $urandom(),    1'b1, 32'd0,   7'd0, smeu_pkg::FLT_UNDER);
		add_row(smeu_pkg::OP_NOP,   $urandom(),    1'b1, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_PUSH,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 7'd1,
			smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_PUSH,  32'h8000_0000, 1'b1, 32'h8000_0000, 7'd2,
			smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_DUP,   $urandom(),    1'b1, 32'h8000_0000, 7'd3,
			smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_AND,   $urandom(),    1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_NAND,  $urandom(),    1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_PUSH,  32'd0,         1'b1, 32'd0,   7'd2, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_NOR,   $urandom(),    1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_PUSH,  32'd5,         1'b1, 32'd5,   7'd2, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_OR,    $urandom(),    1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_DUP,   $urandom(),    1'b1, 32'd5,   7'd2, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_IFEQ,  $urandom(),    1'b1, 32'd5,   7'd2, smeu_pkg::FLT_UNDER);
		add_row(smeu_pkg::OP_ADD,   $urandom(),    1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_PUSH,  32'd10,        1'b1, 32'd10,  7'd2, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_DUP,   $urandom(),    1'b1, 32'd10,  7'd3, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_IFEQ,  $urandom(),    1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_PUSH,  32'd33,        1'b1, 32'd33,  7'd1, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_PUSH,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 7'd2,
			smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_ASR,   $urandom(),    1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_PUSH,  32'd1,         1'b1, 32'd1,   7'd2, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_SHL,   $urandom(),    1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_PUSH,  32'd2,         1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_PUSH,  smeu_pkg::CMP_LT, 1'b0, 32'd0, 7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_CMP,   $urandom(),    1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_PRINT, $urandom(),    1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);
		add_row(smeu_pkg::OP_JUMP,  $urandom(),    1'b0, 32'd0,   7'd0, smeu_pkg::FLT_NONE);

		idle_pct = idle_plan[0];
		foreach (dir_rows[i]) issue(dir_rows[i].op, dir_rows[i].imm, dir_rows[i].typed,
			dir_rows[i].res);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = idle_plan[ph];
			while (words_sent < dir_rows.size() + (ph + 1) * 240) begin
				play_sequence();
				if ($urandom_range(0, 49) == 0) drain();
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Ran %0d words, checked %0d results: %0d underflows, %0d overflows,",
			words_sent, results_seen, n_under, n_over);
		$display("%0d jumps, %0d prints, deepest stack %0d of %0d, mismatches %0d",
			n_jump, n_print, deepest, DEPTH, errors);
		if (errors == 0) begin
			$display("** stack_machine_execute_unit: PASSED **");
		end else begin
			$display("** stack_machine_execute_unit: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
hdl/smeu_pkg.sv
hdl/smeu_ram.sv
hdl/smeu_ctrl.sv
hdl/smeu_dp.sv
hdl/stack_machine_execute_unit.sv
sim/tb.sv
